@@ src/fca_pkg.sv @@
// fca_pkg: opcodes, status codes, link markers and the result record
// shared by the chain allocator, its table RAM users and its checker.
// No dependencies.
package fca_pkg;

  // Width of an index that the 8-bit entries_in_use can reach
  localparam int IDX_W = 8;
  // Width of a scan counter that must also hold the active count itself
  localparam int CNT_W = 9;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;
  localparam logic [1:0] OP_FREE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_BROKEN  = 2'd3;

  localparam logic [31:0] LINK_END  = 32'hFFFF_FFFF;
  localparam logic [31:0] LINK_FREE = 32'h0000_0000;

  // Register map: bit 2 of the byte address selects the register
  localparam logic       REG_ENTRIES_IN_USE = 1'b0;
  localparam logic [7:0] ENTRIES_RST        = 8'd128;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [7:0]  touched;
  } fca_result_t;

endpackage

@@ src/fca_ram.sv @@
// fca_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/fat_chain_allocator_top.sv @@
// fat_chain_allocator_top: allocation-table chain allocator, top level.
// Depends on fca_pkg and fca_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat:
//   load an entry, read an entry, allocate a chain of block_count entries
//   (first fit, ascending) or free a chain from entry_index. Each beat gives
//   exactly one result beat on the output channel (out_valid / out_stall):
//   status, result_value and entries_touched.
//   The table lives in one RAM with a single read and a single write port and
//   registered read data; allocate and free are read-modify-write walks.
//   One operation runs at a time; in_stall is high while it is in progress.
//   Steps from accept to result beat: an out-of-range index goes straight to
//   the result, a load writes its entry, a read waits for its data, allocate
//   runs a counting scan, then a linking scan, then the end marker write (with
//   too few free entries it answers after the counting scan), and free reads,
//   then clears and checks, each chain entry that it visits.
//   The result sits in an output register, so a new beat is taken while the
//   previous result still waits; a finished operation holds in its done state
//   until the output register frees up.
//   Reset (rst_n low, synchronous) clears control state and sets
//   entries_in_use to 128. Table contents are not cleared; entries must be
//   loaded or allocated before they are read.
module fat_chain_allocator_top
  import fca_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // operation channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [6:0]  in_entry_index,
  input  logic [31:0] in_entry_value,
  input  logic [7:0]  in_block_count,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_value,
  output logic [7:0]  out_entries_touched,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = (AW > CNT_W) ? AW : CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;  // read data arrives
  localparam logic [2:0] S_CNT  = 3'd2;  // count free entries
  localparam logic [2:0] S_LINK = 3'd3;  // link free entries
  localparam logic [2:0] S_TERM = 3'd4;  // mark chain end
  localparam logic [2:0] S_FCHK = 3'd5;  // clear entry, follow link
  localparam logic [2:0] S_FRD  = 3'd6;  // read next chain entry
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to output register

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       cfg_entries_r;
  logic [7:0]       want_r, want_nxt;
  logic [7:0]       found_r, found_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [7:0]       touched_r, touched_nxt;
  fca_result_t      res_r, res_nxt;
  fca_result_t      out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] n_act;
  logic             in_accept;
  logic             in_range;
  logic [7:0]       want_in;
  logic [31:0]      mem_rdata;
  logic             mem_we;
  logic [XW-1:0]    mem_waddr_x;
  logic [XW-1:0]    mem_raddr_x;
  logic [31:0]      mem_wdata;
  logic             chk_hit;
  logic [IDX_W-1:0] chk_idx;
  logic [7:0]       found_inc;
  logic [7:0]       touched_inc;
  logic             cfg_write;

  // Active entry count: 0 reads as 1, clamp to the table depth
  always_comb begin
    if (cfg_entries_r == 8'd0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_entries_r) > TABLE_DEPTH) begin
      n_act = CNT_W'(TABLE_DEPTH);
    end else begin
      n_act = {1'b0, cfg_entries_r};
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign in_range    = {2'b00, in_entry_index} < n_act;
  assign want_in     = (in_block_count == 8'd0) ? 8'd1 : in_block_count;
  // During a scan the RAM data belongs to the entry issued in the previous cycle
  assign chk_hit     = (scan_r != '0) && (mem_rdata == LINK_FREE);
  assign chk_idx     = IDX_W'(scan_r - CNT_W'(1));
  assign found_inc   = found_r + 8'd1;
  assign touched_inc = touched_r + 8'd1;

  always_comb begin
    state_nxt     = state_r;
    want_nxt      = want_r;
    found_nxt     = found_r;
    scan_nxt      = scan_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    touched_nxt   = touched_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr_x   = XW'(cur_r);
    mem_wdata     = LINK_FREE;
    mem_raddr_x   = XW'(scan_r);

    case (state_r)
      S_IDLE: begin
        mem_raddr_x = XW'(in_entry_index);
        if (in_accept) begin
          if (in_opcode == OP_ALLOC) begin
            want_nxt  = want_in;
            found_nxt = 8'd0;
            scan_nxt  = '0;
            state_nxt = S_CNT;
          end else if (!in_range) begin
            res_nxt   = '{status: ST_RANGE, value: 32'd0, touched: 8'd0};
            state_nxt = S_DONE;
          end else begin
            case (in_opcode)
              OP_LOAD: begin
                mem_we      = 1'b1;
                mem_waddr_x = XW'(in_entry_index);
                mem_wdata   = in_entry_value;
                res_nxt     = '{status: ST_OK, value: 32'd0, touched: 8'd0};
                state_nxt   = S_DONE;
              end
              OP_READ: begin
                state_nxt = S_READ;
              end
              default: begin
                cur_nxt     = IDX_W'(in_entry_index);
                touched_nxt = 8'd0;
                state_nxt   = S_FCHK;
              end
            endcase
          end
        end
      end

      S_READ: begin
        res_nxt   = '{status: ST_OK, value: mem_rdata, touched: 8'd0};
        state_nxt = S_DONE;
      end

      S_CNT: begin
        // Issue one read per cycle; stop early once enough are found
        if (chk_hit && (found_inc == want_r)) begin
          found_nxt = 8'd0;
          scan_nxt  = '0;
          state_nxt = S_LINK;
        end else if (scan_r == n_act) begin
          res_nxt   = '{status: ST_NOSPACE, value: 32'd0, touched: 8'd0};
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
          if (chk_hit) begin
            found_nxt = found_inc;
          end
        end
      end

      S_LINK: begin
        // The counting pass guarantees enough hits before scan_r passes n
        scan_nxt = scan_r + CNT_W'(1);
        if (chk_hit) begin
          if (found_r == 8'd0) begin
            first_nxt = chk_idx;
          end else begin
            mem_we      = 1'b1;
            mem_waddr_x = XW'(prev_r);
            mem_wdata   = 32'(chk_idx);
          end
          prev_nxt  = chk_idx;
          found_nxt = found_inc;
          if (found_inc == want_r) begin
            state_nxt = S_TERM;
          end
        end
      end

      S_TERM: begin
        mem_we      = 1'b1;
        mem_waddr_x = XW'(prev_r);
        mem_wdata   = LINK_END;
        res_nxt     = '{status: ST_OK, value: 32'(first_r), touched: want_r};
        state_nxt   = S_DONE;
      end

      S_FRD: begin
        mem_raddr_x = XW'(cur_r);
        state_nxt   = S_FCHK;
      end

      S_FCHK: begin
        // Clear the current entry, then judge its link
        mem_we      = 1'b1;
        mem_waddr_x = XW'(cur_r);
        mem_wdata   = LINK_FREE;
        touched_nxt = touched_inc;
        if (mem_rdata == LINK_END) begin
          res_nxt   = '{status: ST_OK, value: 32'd0, touched: touched_inc};
          state_nxt = S_DONE;
        end else if ((mem_rdata == LINK_FREE) || (mem_rdata >= 32'(n_act)) ||
                     ({1'b0, touched_inc} == n_act)) begin
          res_nxt   = '{status: ST_BROKEN, value: 32'd0, touched: touched_inc};
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = mem_rdata[IDX_W-1:0];
          state_nxt = S_FRD;
        end
      end

      S_DONE: begin
        // Hold until the output register is empty or being drained
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  fca_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr_x[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr_x[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Configuration: one register, written in the APB access phase
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_ENTRIES_IN_USE);
  assign cfg_prdata = (cfg_paddr[2] == REG_ENTRIES_IN_USE) ?
                      {24'd0, cfg_entries_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      cfg_entries_r <= ENTRIES_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        cfg_entries_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    want_r    <= want_nxt;
    found_r   <= found_nxt;
    scan_r    <= scan_nxt;
    prev_r    <= prev_nxt;
    first_r   <= first_nxt;
    cur_r     <= cur_nxt;
    touched_r <= touched_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_result_value    = out_r.value;
  assign out_entries_touched = out_r.touched;

endmodule

@@ src/fca_checker.sv @@
// fca_checker: port-level checks for fat_chain_allocator_top, plus its bind.
// Depends on fca_pkg.
module fca_checker
  import fca_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_result_value,
  input logic [7:0]  out_entries_touched
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_result_value) && $stable(out_entries_touched))
    else $error("stalled result beat changed");

  // One operation at a time: an accepted beat blocks the next
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation runs");

  // Failed range check or allocation leaves no trace in the result
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANGE || out_status == ST_NOSPACE) |->
    out_result_value == 32'd0 && out_entries_touched == 8'd0)
    else $error("failed operation reports a value or touched entries");

  // A broken chain is only found after clearing at least one entry
  a_broken_touched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BROKEN |->
    out_entries_touched != 8'd0 && out_result_value == 32'd0)
    else $error("broken chain result without cleared entries");

endmodule

bind fat_chain_allocator_top fca_checker u_fca_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_result_value    (out_result_value),
  .out_entries_touched (out_entries_touched)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for fat_chain_allocator_top.
// Depends on fca_pkg and the allocator RTL; predicts every result beat in-line.
module testbench
  import fca_pkg::*;
();

  localparam int DEPTH          = 128;
  localparam int IDLE_CYCLES    = 8;     // settle time before a register write
  localparam int END_CYCLES     = 300;   // longer than the slowest allocate
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on any port

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [6:0]  in_entry_index;
  logic [31:0] in_entry_value;
  logic [7:0]  in_block_count;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_result_value;
  logic [7:0]  out_entries_touched;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the allocation table and of entries_in_use
  logic [31:0] fat_image [DEPTH];
  logic [7:0]  limit_reg;

  fca_result_t pending_results[$];   // predicted beats, oldest first
  int          chain_heads[$];       // first index of every chain still allocated
  int          error_count = 0;
  int          send_gap_max;         // sender idle draw per beat, 0 = back to back
  int          stall_max;            // receiver stall draw per beat, 0 = never stall
  int          hold_request = 0;     // one-shot long hold-off for the receiver

  fat_chain_allocator_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_entry_index      (in_entry_index),
    .in_entry_value      (in_entry_value),
    .in_block_count      (in_block_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_value    (out_result_value),
    .out_entries_touched (out_entries_touched),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Active entry count: zero reads as one, anything past the table clamps to it
  function automatic int active_entries();
    int n;
    n = limit_reg;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // Run one operation against the shadow table and return the beat it must produce
  function automatic fca_result_t apply_fat_op(input logic [1:0] op, input logic [6:0] idx,
                                               input logic [31:0] val, input logic [7:0] cnt);
    fca_result_t res;
    int          n;
    int          want;
    int          found;
    int          first;
    int          prev;
    int          cur;
    int          touched;
    int          i;
    logic [31:0] nxt;
    res   = '0;
    n     = active_entries();
    first = 0;
    prev  = 0;
    if (op == OP_ALLOC) begin
      want  = (cnt == 8'd0) ? 1 : int'(cnt);
      found = 0;
      // count pass: bail out with no change if the free entries fall short
      for (i = 0; i < n && found < want; i++)
        if (fat_image[i] == LINK_FREE) found++;
      if (found < want) begin
        res.status = ST_NOSPACE;
      end else begin
        // link pass: chain the lowest free entries, terminate the last one
        found = 0;
        for (i = 0; i < n && found < want; i++) begin
          if (fat_image[i] == LINK_FREE) begin
            if (found == 0) first = i;
            else fat_image[prev] = 32'(i);
            prev = i;
            found++;
          end
        end
        fat_image[prev] = LINK_END;
        res.status  = ST_OK;
        res.value   = 32'(first);
        res.touched = 8'(want);
      end
    end else if (int'(idx) >= n) begin
      res.status = ST_RANGE;
    end else begin
      case (op)
        OP_LOAD: begin
          fat_image[idx] = val;
          res.status     = ST_OK;
        end
        OP_READ: begin
          res.status = ST_OK;
          res.value  = fat_image[idx];
        end
        default: begin
          // free walk: clear first, then judge the link; stop after n clears
          cur        = idx;
          touched    = 0;
          res.status = ST_BROKEN;
          while (touched < n) begin
            nxt            = fat_image[cur];
            fat_image[cur] = LINK_FREE;
            touched++;
            if (nxt == LINK_END) begin
              res.status = ST_OK;
              break;
            end
            if (nxt == LINK_FREE || nxt >= 32'(n)) break;
            cur = int'(nxt);
          end
          res.touched = 8'(touched);
        end
      endcase
    end
    return res;
  endfunction

  // Mostly short chains, some up to the whole table, a few zero and oversize counts
  function automatic logic [7:0] alloc_size(input int n);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 8'($urandom_range(1, (n < 8) ? n : 8));
    if (sel < 85) return 8'($urandom_range(1, n));
    if (sel < 92) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one beat after a random idle gap, hold it until taken, then predict it
  task automatic send_op(input logic [1:0] op, input logic [6:0] idx,
                         input logic [31:0] val, input logic [7:0] cnt);
    int          gap;
    int          k;
    fca_result_t predicted;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_block_count <= cnt;
    do @(posedge clk); while (in_stall);
    predicted = apply_fat_op(op, idx, val, cnt);
    pending_results.push_back(predicted);
    // track live chains so the traffic can free and read them later
    if (op == OP_ALLOC && predicted.status == ST_OK)
      chain_heads.push_back(int'(predicted.value));
    if (op == OP_FREE)
      for (k = chain_heads.size() - 1; k >= 0; k--)
        if (chain_heads[k] == int'(idx)) chain_heads.delete(k);
  endtask

  // Drop valid and wait for every predicted beat, then idle a little longer
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Setup cycle then access cycle; the register takes the value at the access edge
  task automatic write_entries_in_use(input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    limit_reg = value;
  endtask

  // Load a free marker into every active entry so nothing unwritten is ever read
  task automatic clear_active_entries();
    int k;
    int n;
    n = active_entries();
    for (k = 0; k < n; k++) send_op(OP_LOAD, 7'(k), LINK_FREE, 8'd0);
    chain_heads.delete();
  endtask

  task automatic test_table_init();
    send_gap_max = 0;
    stall_max    = 0;
    clear_active_entries();
  endtask

  // Whole-table chain: count of 128, read both ends, free it in one go
  task automatic test_full_allocation();
    send_gap_max = 4;
    stall_max    = 4;
    send_op(OP_ALLOC, 7'd0, 32'd0, 8'd128);
    send_op(OP_READ, 7'd127, 32'd0, 8'd0);
    send_op(OP_READ, 7'd0, 32'd0, 8'd0);
    send_op(OP_FREE, 7'd0, 32'd0, 8'd0);
  endtask

  // Extreme indexes and alternating bit patterns through load and read
  task automatic test_load_read_extremes();
    send_op(OP_LOAD, 7'd127, LINK_END, 8'd0);
    send_op(OP_READ, 7'd127, 32'd0, 8'd0);
    send_op(OP_LOAD, 7'd64, 32'h5A5A_A5A5, 8'hFF);
    send_op(OP_READ, 7'd64, 32'h0, 8'd0);
    send_op(OP_LOAD, 7'd64, 32'hA5A5_5A5A, 8'd0);
    send_op(OP_READ, 7'd64, 32'hFFFF_FFFF, 8'd0);
    send_op(OP_LOAD, 7'd64, LINK_FREE, 8'd0);
    send_op(OP_LOAD, 7'd127, LINK_FREE, 8'd0);
  endtask

  // Zero count as one, a short chain, an oversize request, then free both
  task automatic test_chain_alloc_free();
    send_op(OP_ALLOC, 7'd0, 32'd0, 8'd0);
    send_op(OP_ALLOC, 7'd0, 32'd0, 8'd3);
    send_op(OP_READ, 7'd1, 32'd0, 8'd0);
    send_op(OP_ALLOC, 7'd0, 32'd0, 8'd255);
    send_op(OP_FREE, 7'd1, 32'd0, 8'd0);
    send_op(OP_FREE, 7'd0, 32'd0, 8'd0);
  endtask

  // Free from a free entry, and a two-entry loop that runs into its own cleared head
  task automatic test_broken_chains();
    send_op(OP_FREE, 7'd10, 32'd0, 8'd0);
    send_op(OP_LOAD, 7'd30, 32'd31, 8'd0);
    send_op(OP_LOAD, 7'd31, 32'd30, 8'd0);
    send_op(OP_FREE, 7'd30, 32'd0, 8'd0);
    send_op(OP_READ, 7'd31, 32'd0, 8'd0);
  endtask

  // Shrink the active window: indexes past it, oversize allocate, link past it
  task automatic test_range_limits();
    drain_results(IDLE_CYCLES);
    write_entries_in_use(8'd16);
    send_op(OP_ALLOC, 7'd0, 32'd0, 8'd17);
    send_op(OP_READ, 7'd100, 32'd0, 8'd0);
    send_op(OP_LOAD, 7'd127, 32'd5, 8'd0);
    send_op(OP_FREE, 7'd16, 32'd0, 8'd0);
    send_op(OP_LOAD, 7'd3, 32'd40, 8'd0);
    send_op(OP_FREE, 7'd3, 32'd0, 8'd0);
  endtask

  // Receiver holds off for a long stretch while beats keep coming back to back
  task automatic test_backpressure();
    int k;
    drain_results(IDLE_CYCLES);
    send_gap_max = 0;
    stall_max    = 0;
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 6; k++) send_op(OP_READ, 7'(k), 32'd0, 8'd0);
    for (k = 0; k < 4; k++) send_op(OP_ALLOC, 7'd0, 32'd0, 8'd2);
    while (chain_heads.size() > 0) send_op(OP_FREE, 7'(chain_heads[0]), 32'd0, 8'd0);
  endtask

  // Sender goes quiet until the block has answered everything, then resumes
  task automatic test_sender_pause();
    int k;
    send_gap_max = 16;
    stall_max    = 16;
    for (k = 0; k < 8; k++) send_op(2'(k), 7'(k), 32'd0, 8'd1);
    drain_results(0);
    for (k = 0; k < 8; k++) send_op(2'(k + 1), 7'(k + 8), LINK_END, 8'd1);
  endtask

  // One register setting: clear the window, then mostly well-formed chain traffic
  task automatic test_random_traffic(input logic [7:0] limit, input int items,
                                     input int gap_max, input int stall_lim);
    int          n;
    int          sel;
    logic [6:0]  idx;
    logic [31:0] link;
    drain_results(IDLE_CYCLES);
    write_entries_in_use(limit);
    n            = active_entries();
    send_gap_max = 0;
    stall_max    = 0;
    clear_active_entries();
    send_gap_max = gap_max;
    stall_max    = stall_lim;
    repeat (items) begin
      sel = $urandom_range(0, 99);
      if (sel < 25 && chain_heads.size() > 0) begin
        idx = 7'(chain_heads[$urandom_range(0, chain_heads.size() - 1)]);
        send_op(OP_FREE, idx, $urandom, 8'($urandom));
      end else if (sel < 60) begin
        send_op(OP_ALLOC, 7'($urandom), $urandom, alloc_size(n));
      end else if (sel < 75) begin
        if (chain_heads.size() > 0 && $urandom_range(0, 1) == 0)
          idx = 7'(chain_heads[$urandom_range(0, chain_heads.size() - 1)]);
        else
          idx = 7'($urandom_range(0, n - 1));
        send_op(OP_READ, idx, $urandom, 8'($urandom));
      end else if (sel < 85) begin
        // well-formed table image content
        case ($urandom_range(0, 2))
          0:       link = LINK_FREE;
          1:       link = LINK_END;
          default: link = 32'($urandom_range(0, n - 1));
        endcase
        send_op(OP_LOAD, 7'($urandom_range(0, n - 1)), link, 8'($urandom));
      end else begin
        // noise: any opcode, any index, any value
        send_op(2'($urandom), 7'($urandom), $urandom, 8'($urandom));
      end
    end
  endtask

  // Receiver: draw a stall before each result beat, or take a one-shot hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        stall_left = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: compare each taken beat with the oldest prediction
  initial begin
    fca_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing predicted: status %0d value %0h touched %0d",
                 out_status, out_result_value, out_entries_touched);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_result_value !== want.value) begin
            $error("result_value: expected %0h, got %0h", want.value, out_result_value);
            error_count++;
          end
          if (out_entries_touched !== want.touched) begin
            $error("entries_touched: expected %0d, got %0d", want.touched,
                   out_entries_touched);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on any port for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("fat_chain_allocator_top test failed");
    $finish;
  end

  initial begin
    // drive every input from time zero, starting with reset held low
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_LOAD;
    in_entry_index <= 7'd0;
    in_entry_value <= 32'd0;
    in_block_count <= 8'd0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= 3'd0;
    cfg_pwdata     <= 32'd0;
    send_gap_max = 0;
    stall_max    = 0;
    limit_reg    = ENTRIES_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_init();
    test_full_allocation();
    test_load_read_extremes();
    test_chain_alloc_free();
    test_broken_chains();
    test_range_limits();

    // walk the register through its extremes and out-of-spec values
    test_random_traffic(8'd128, 180, 16, 16);
    test_backpressure();
    test_sender_pause();
    test_random_traffic(8'd1, 100, 0, 0);
    test_random_traffic(8'd16, 250, 0, 16);
    test_random_traffic(8'd5, 150, 16, 0);
    test_random_traffic(8'd0, 80, 16, 16);
    test_random_traffic(8'd200, 200, 4, 4);
    test_random_traffic(8'd64, 170, 16, 16);
    test_random_traffic(8'd128, 100, 0, 0);

    // let the last beats land, then watch for strays
    drain_results(END_CYCLES);
    if (error_count == 0 && pending_results.size() == 0)
      $display("fat_chain_allocator_top test passed");
    else
      $display("fat_chain_allocator_top test failed");
    $finish;
  end

endmodule
